@@ hw/rtl/psns_pkg.sv @@
package psns_pkg;

   // Defaults for the top-level parameters
   localparam int NOTE_DEPTH_DEF   = 256;
   localparam int VOICES_DEF       = 3;
   localparam int SINE_ENTRIES_DEF = 64;

   // Each score entry holds at most this many phase steps
   localparam int STORED_STEPS = 3;

   // Phase accumulator to sine table index
   localparam int         PHASE_SHIFT = 26;
   localparam logic [5:0] PHASE_MASK  = 6'h3F;

   // Envelope: ramp length in samples and full-scale gain
   localparam logic [15:0] RAMP     = 16'd500;
   localparam logic [8:0]  FULL_VOL = 9'd256;

   // floor(x*256/500) == (x*RECIP_RAMP) >> 16 for every x below 500
   localparam logic [15:0] RECIP_RAMP = 16'd33555;
   // floor(x/3) == (x*RECIP_THREE) >> 17 for every x below 2**16
   localparam logic [15:0] RECIP_THREE = 16'd43691;

   // Request commands
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_LOAD    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Register indexes
   localparam int         CSR_INDEX_W     = 2;
   localparam int         CSR_DATA_W      = 9;
   localparam logic [1:0] CSR_SONG_START  = 2'd0;
   localparam logic [1:0] CSR_SONG_LENGTH = 2'd1;

   // 64-entry 12-bit sine table
   localparam logic [11:0] SINE_ROM [64] = '{
      12'd2048, 12'd2248, 12'd2447, 12'd2642, 12'd2831, 12'd3013, 12'd3185, 12'd3346,
      12'd3495, 12'd3630, 12'd3750, 12'd3853, 12'd3939, 12'd4007, 12'd4056, 12'd4085,
      12'd4095, 12'd4085, 12'd4056, 12'd4007, 12'd3939, 12'd3853, 12'd3750, 12'd3630,
      12'd3495, 12'd3346, 12'd3185, 12'd3013, 12'd2831, 12'd2642, 12'd2447, 12'd2248,
      12'd2048, 12'd1847, 12'd1648, 12'd1453, 12'd1264, 12'd1082, 12'd910,  12'd749,
      12'd600,  12'd465,  12'd345,  12'd242,  12'd156,  12'd88,   12'd39,   12'd10,
      12'd0,    12'd10,   12'd39,   12'd88,   12'd156,  12'd242,  12'd345,  12'd465,
      12'd600,  12'd749,  12'd910,  12'd1082, 12'd1264, 12'd1453, 12'd1648, 12'd1847
   };

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  note_addr;
      logic [31:0] step_voice0;
      logic [31:0] step_voice1;
      logic [31:0] step_voice2;
      logic [15:0] note_length;
      logic [1:0]  voice_count;
   } psns_req_type;

   typedef struct packed {
      logic [11:0] dac_sample;
      logic [7:0]  note_position;
      logic        song_wrapped;
   } psns_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic restart;
      logic fetch;
      logic voice;
      logic scale;
      logic mix;
   } psns_ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic out_full;
   } psns_stat_type;

endpackage

@@ hw/rtl/psns_ctrl.sv @@
module psns_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_cmd,
   output logic                    req_ready,
   input  psns_pkg::psns_stat_type stat,
   output psns_pkg::psns_ctl_type  ctl
);
   import psns_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_VOICE = 2'd1;
   localparam logic [1:0] ST_SCALE = 2'd2;
   localparam logic [1:0] ST_MIX   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      ctl         = '0;
      ctl.load    = accept & (req_cmd == CMD_LOAD);
      ctl.restart = accept & (req_cmd == CMD_RESTART);
      ctl.fetch   = accept & (req_cmd == CMD_TICK);
      ctl.voice   = (state_ff == ST_VOICE);
      ctl.scale   = (state_ff == ST_SCALE);
      ctl.mix     = (state_ff == ST_MIX) & ~stat.out_full;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (ctl.fetch) state_in = ST_VOICE;
         ST_VOICE: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MIX;
         ST_MIX:   if (ctl.mix) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/psns_datapath.sv @@
module psns_datapath #(
   parameter int NOTE_DEPTH   = 256,
   parameter int VOICES       = 3,
   parameter int SINE_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  psns_pkg::psns_ctl_type            ctl,
   output psns_pkg::psns_stat_type           stat,
   input  psns_pkg::psns_req_type            req_data,
   input  logic                              csr_write,
   input  logic [psns_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [psns_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output psns_pkg::psns_rsp_type            rsp_data
);
   import psns_pkg::*;

   localparam int ADDR_W = $clog2(NOTE_DEPTH);
   localparam int PHASES = (VOICES < STORED_STEPS) ? VOICES : STORED_STEPS;

   typedef struct packed {
      logic [PHASES-1:0][31:0] steps;
      logic [15:0]             length;
      logic [1:0]              voices;
   } row_type;

   row_type                      score_mem [NOTE_DEPTH];
   row_type                      row_ff;
   row_type                      wr_row;
   logic [STORED_STEPS-1:0][31:0] step_in;

   logic [7:0]        song_start_ff;
   logic [8:0]        song_length_ff;
   logic [31:0]       phase_ff [PHASES];
   logic [31:0]       phase_in [PHASES];
   logic [7:0]        offset_ff;
   logic [7:0]        offset_in;
   logic [15:0]       count_ff;
   logic [15:0]       count_in;

   logic [8:0]        raw_addr;
   logic [17:0]       red_addr;
   logic [ADDR_W-1:0] mem_addr;

   logic [1:0]        nv_clamp;
   logic [13:0]       sum_in;
   logic [11:0]       sine_val [PHASES];
   logic              note_end;
   logic [8:0]        next_offset;
   logic              wrap_in;
   logic [8:0]        x_in;
   logic              sustain_in;

   logic [13:0]       sum_ff;
   logic [1:0]        nv_ff;
   logic [8:0]        x_ff;
   logic              sustain_ff;
   logic [7:0]        played_ff;
   logic              wrapped_ff;

   logic [29:0]       prod_three;
   logic [24:0]       prod_env;
   logic [11:0]       avg_in;
   logic [8:0]        env_in;
   logic [11:0]       avg_ff;
   logic [8:0]        env_ff;
   logic [20:0]       prod_mix;

   logic              rsp_valid_ff;
   psns_rsp_type      rsp_data_ff;

   // Score address: the load address, or start plus offset, folded back into the memory depth
   always_comb begin
      if (ctl.load) begin
         raw_addr = {1'b0, req_data.note_addr};
      end else begin
         raw_addr = {1'b0, song_start_ff} + {1'b0, offset_ff};
      end
      red_addr = {9'd0, raw_addr};
      for (int k = 5; k >= 0; k--) begin
         if (red_addr >= (18'(NOTE_DEPTH) << k)) begin
            red_addr = red_addr - (18'(NOTE_DEPTH) << k);
         end
      end
   end
   assign mem_addr = red_addr[ADDR_W-1:0];

   assign step_in = {req_data.step_voice2, req_data.step_voice1, req_data.step_voice0};

   always_comb begin
      wr_row        = '0;
      wr_row.steps  = step_in[PHASES-1:0];
      wr_row.length = req_data.note_length;
      wr_row.voices = req_data.voice_count;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         score_mem[mem_addr] <= wr_row;
      end
      if (ctl.fetch) begin
         row_ff <= score_mem[mem_addr];
      end
   end

   // Voice stage: table reads, phase advance, envelope position, note end
   always_comb begin
      logic [5:0]  idx;
      logic [10:0] red_idx;
      nv_clamp = (row_ff.voices > 2'(PHASES)) ? 2'(PHASES) : row_ff.voices;
      sum_in   = '0;
      note_end = ({1'b0, count_ff} + 17'd1) >= {1'b0, row_ff.length};
      for (int v = 0; v < PHASES; v++) begin
         idx     = 6'(phase_ff[v] >> PHASE_SHIFT) & PHASE_MASK;
         red_idx = {5'd0, idx};
         for (int k = 2; k >= 0; k--) begin
            if (red_idx >= (11'(SINE_ENTRIES) << k)) begin
               red_idx = red_idx - (11'(SINE_ENTRIES) << k);
            end
         end
         sine_val[v] = SINE_ROM[red_idx[5:0]];
         phase_in[v] = phase_ff[v];
         if (2'(v) < nv_clamp) begin
            sum_in      = sum_in + {2'd0, sine_val[v]};
            phase_in[v] = phase_ff[v] + row_ff.steps[v];
         end
         if (note_end) begin
            phase_in[v] = '0;
         end
      end
   end

   always_comb begin
      next_offset = {1'b0, offset_ff} + 9'd1;
      wrap_in     = 1'b0;
      offset_in   = next_offset[7:0];
      count_in    = count_ff + 16'd1;
      if (note_end) begin
         count_in = '0;
         if ((next_offset >= song_length_ff) || next_offset[8]) begin
            offset_in = '0;
            wrap_in   = 1'b1;
         end
      end else begin
         offset_in = offset_ff;
      end
   end

   // Attack, release or sustain
   always_comb begin
      x_in       = '0;
      sustain_in = 1'b0;
      if (count_ff < RAMP) begin
         x_in = count_ff[8:0];
      end else if ((row_ff.length >= RAMP) && (count_ff > row_ff.length - RAMP)) begin
         if (count_ff < row_ff.length) begin
            x_in = 9'(row_ff.length - count_ff);
         end
      end else begin
         sustain_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.voice) begin
         sum_ff     <= sum_in;
         nv_ff      <= nv_clamp;
         x_ff       <= x_in;
         sustain_ff <= sustain_in;
         played_ff  <= offset_ff;
         wrapped_ff <= wrap_in;
      end
   end

   // Scale stage: average the voices, turn the envelope position into a gain
   assign prod_three = 30'(sum_ff) * 30'(RECIP_THREE);
   assign prod_env   = 25'(x_ff) * 25'(RECIP_RAMP);

   always_comb begin
      unique case (nv_ff)
         2'd1:    avg_in = sum_ff[11:0];
         2'd2:    avg_in = sum_ff[12:1];
         2'd3:    avg_in = prod_three[28:17];
         default: avg_in = '0;
      endcase
      env_in = sustain_ff ? FULL_VOL : prod_env[24:16];
   end

   always_ff @(posedge clock) begin
      if (ctl.scale) begin
         avg_ff <= avg_in;
         env_ff <= env_in;
      end
   end

   // Mix stage: apply the gain and load the output register
   assign prod_mix = 21'(avg_ff) * 21'(env_ff);

   always_ff @(posedge clock) begin
      if (ctl.mix) begin
         rsp_data_ff.dac_sample    <= prod_mix[19:8];
         rsp_data_ff.note_position <= played_ff;
         rsp_data_ff.song_wrapped  <= wrapped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         song_start_ff  <= '0;
         song_length_ff <= 9'd1;
         offset_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int v = 0; v < PHASES; v++) begin
            phase_ff[v] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SONG_START:  song_start_ff  <= csr_data[7:0];
               CSR_SONG_LENGTH: song_length_ff <= csr_data;
               default: ;
            endcase
         end
         if (ctl.restart) begin
            offset_ff <= '0;
            count_ff  <= '0;
            for (int v = 0; v < PHASES; v++) begin
               phase_ff[v] <= '0;
            end
         end else if (ctl.voice) begin
            offset_ff <= offset_in;
            count_ff  <= count_in;
            for (int v = 0; v < PHASES; v++) begin
               phase_ff[v] <= phase_in[v];
            end
         end
         if (ctl.mix) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_full = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

@@ hw/rtl/polyphonic_sine_note_sequencer.sv @@
// Polyphonic sine note sequencer. Load notes into the score memory with load
// requests (three 32-bit phase steps, a length in samples and a voice count
// per entry), set song_start and song_length through the register port, then
// send one tick request per audio sample; each tick returns one response with
// the enveloped 12-bit sample, the note's offset within the song and a flag
// that marks the tick that ended the last note and looped. Load, restart and
// the unused command code return no response and leave the block idle. A tick
// passes through a registered score memory read, the voice stage (sine table
// reads and phase advance), the scale stage (voice average and envelope gain,
// one multiplier each) and the mix stage (gain multiply into the output
// register); it stays longer in the mix stage only while the previous
// response still waits to be taken. A score entry that was never loaded
// returns an unspecified sample. Write registers only while no tick is in
// flight. The score memory needs no clearing pass after reset.
module polyphonic_sine_note_sequencer #(
   parameter int NOTE_DEPTH   = psns_pkg::NOTE_DEPTH_DEF,
   parameter int VOICES       = psns_pkg::VOICES_DEF,
   parameter int SINE_ENTRIES = psns_pkg::SINE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  psns_pkg::psns_req_type            req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output psns_pkg::psns_rsp_type            rsp_data,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psns_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [psns_pkg::CSR_DATA_W-1:0]   csr_data
);
   import psns_pkg::*;

   psns_ctl_type  ctl;
   psns_stat_type stat;

   // Registers are always writable; an unknown index is dropped
   assign csr_ready = 1'b1;

   // Sequence each request: decode the command, step the tick through its stages
   psns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Score memory, phases, play position, envelope and output register
   psns_datapath #(
      .NOTE_DEPTH   (NOTE_DEPTH),
      .VOICES       (VOICES),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ verif/psns_sample_checker.sv @@
module psns_sample_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  psns_pkg::psns_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  psns_pkg::psns_rsp_type rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_data,
   output int unsigned            mismatches,
   output int unsigned            awaiting,
   output int unsigned            loops_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import psns_pkg::*;

   localparam int unsigned ENV_RAMP = RAMP;
   localparam int unsigned ENV_FULL = FULL_VOL;

   localparam logic [11:0] SINE_TABLE [64] = '{
      12'd2048, 12'd2248, 12'd2447, 12'd2642, 12'd2831, 12'd3013, 12'd3185, 12'd3346,
      12'd3495, 12'd3630, 12'd3750, 12'd3853, 12'd3939, 12'd4007, 12'd4056, 12'd4085,
      12'd4095, 12'd4085, 12'd4056, 12'd4007, 12'd3939, 12'd3853, 12'd3750, 12'd3630,
      12'd3495, 12'd3346, 12'd3185, 12'd3013, 12'd2831, 12'd2642, 12'd2447, 12'd2248,
      12'd2048, 12'd1847, 12'd1648, 12'd1453, 12'd1264, 12'd1082, 12'd910,  12'd749,
      12'd600,  12'd465,  12'd345,  12'd242,  12'd156,  12'd88,   12'd39,   12'd10,
      12'd0,    12'd10,   12'd39,   12'd88,   12'd156,  12'd242,  12'd345,  12'd465,
      12'd600,  12'd749,  12'd910,  12'd1082, 12'd1264, 12'd1453, 12'd1648, 12'd1847
   };

   logic [31:0]  score_steps   [256][3];
   logic [15:0]  score_lengths [256];
   logic [1:0]   score_voices  [256];
   logic [31:0]  voice_phase   [3];
   logic [7:0]   song_first;
   logic [8:0]   song_notes;
   logic [7:0]   play_offset;
   logic [15:0]  play_count;
   psns_rsp_type due_samples [$];

   function automatic int unsigned envelope_gain(input int unsigned played,
                                                 input int unsigned len);
      if (played < ENV_RAMP) return played * ENV_FULL / ENV_RAMP;
      if (len >= ENV_RAMP && played > len - ENV_RAMP) begin
         // a note shortened under the play position falls silent
         if (played >= len) return 0;
         return (len - played) * ENV_FULL / ENV_RAMP;
      end
      return ENV_FULL;
   endfunction

   // Play one sample of the current note and advance the song position.
   function automatic psns_rsp_type play_tick();
      psns_rsp_type r;
      logic [7:0]   slot;
      int unsigned  len, voices, mix, played, next_offset;
      slot   = song_first + play_offset;
      len    = score_lengths[slot];
      voices = score_voices[slot];
      played = play_count;
      mix    = 0;
      r.dac_sample    = '0;
      r.note_position = play_offset;
      r.song_wrapped  = 1'b0;
      for (int v = 0; v < voices; v++) begin
         mix += SINE_TABLE[voice_phase[v][31:26]];
         voice_phase[v] += score_steps[slot][v];
      end
      if (voices != 0)
         r.dac_sample = 12'((mix / voices) * envelope_gain(played, len) / ENV_FULL);
      if (played + 1 >= len) begin
         next_offset = play_offset + 1;
         play_count  = '0;
         for (int v = 0; v < 3; v++) voice_phase[v] = '0;
         if (next_offset >= song_notes || next_offset > 255) begin
            next_offset    = 0;
            r.song_wrapped = 1'b1;
         end
         play_offset = 8'(next_offset);
      end else begin
         play_count = play_count + 16'd1;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      psns_rsp_type want;
      if (reset) begin
         song_first  = '0;
         song_notes  = 9'd1;
         play_offset = '0;
         play_count  = '0;
         for (int v = 0; v < 3; v++) voice_phase[v] = '0;
         due_samples.delete();
         mismatches  = 0;
         loops_seen  = 0;
      end else begin
         // compare first: a sample leaving now belongs to an older tick
         if (rsp_valid && rsp_ready) begin
            if (due_samples.size() == 0) begin
               $error("sample returned while none was due");
               mismatches++;
            end else begin
               want = due_samples.pop_front();
               if (rsp_data.dac_sample !== want.dac_sample) begin
                  $error("dac_sample: expected %0d, got %0d",
                         want.dac_sample, rsp_data.dac_sample);
                  mismatches++;
               end
               if (rsp_data.note_position !== want.note_position) begin
                  $error("note_position: expected %0d, got %0d",
                         want.note_position, rsp_data.note_position);
                  mismatches++;
               end
               if (rsp_data.song_wrapped !== want.song_wrapped) begin
                  $error("song_wrapped: expected %0d, got %0d",
                         want.song_wrapped, rsp_data.song_wrapped);
                  mismatches++;
               end
               if (want.song_wrapped) loops_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SONG_START:  song_first = csr_data[7:0];
               CSR_SONG_LENGTH: song_notes = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.cmd)
               CMD_LOAD: begin
                  score_steps[req_data.note_addr][0] = req_data.step_voice0;
                  score_steps[req_data.note_addr][1] = req_data.step_voice1;
                  score_steps[req_data.note_addr][2] = req_data.step_voice2;
                  score_lengths[req_data.note_addr]  = req_data.note_length;
                  score_voices[req_data.note_addr]   = req_data.voice_count;
               end
               CMD_RESTART: begin
                  play_offset = '0;
                  play_count  = '0;
                  for (int v = 0; v < 3; v++) voice_phase[v] = '0;
               end
               CMD_TICK: due_samples.push_back(play_tick());
               default: ;
            endcase
         end
      end
      awaiting = due_samples.size();
   end

endmodule

@@ verif/polyphonic_sine_note_sequencer_tb.sv @@
module polyphonic_sine_note_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psns_pkg::*;

   // codes the block must ignore
   localparam logic [1:0] CMD_SPARE    = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   localparam int unsigned RANDOM_TARGET  = 380;
   localparam int unsigned CALM_AFTER     = 290;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_LIMIT    = 4000;

   // one long note walks attack, sustain and release, then gets cut short
   localparam logic [7:0]  LONG_SLOT  = 8'd10;
   localparam logic [15:0] LONG_NOTE  = 16'd1003;
   localparam int unsigned LONG_TICKS = 520;
   localparam logic [15:0] CUT_NOTE   = 16'd510;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   psns_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   psns_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [8:0]   csr_data  = '0;

   int unsigned mismatches, awaiting, loops_seen;
   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent = 0, random_base = 0;
   int unsigned ticks_sent = 0, loads_sent = 0, restarts_sent = 0, spares_sent = 0;
   int unsigned settings_used = 0;

   // song window the stimulus keeps loaded: every slot in it holds a short note
   logic [7:0]  window_first = '0;
   int unsigned window_notes = 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   polyphonic_sine_note_sequencer dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   psns_sample_checker sample_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .awaiting, .loops_seen
   );

   // Response side: randomly hold rsp_ready low while idling is on.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Drop the run if no channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Random content for every field; callers overwrite what matters.
   function automatic psns_req_type scrambled_request(input logic [1:0] cmd);
      psns_req_type r;
      r.cmd         = cmd;
      r.note_addr   = 8'($urandom);
      r.step_voice0 = $urandom;
      r.step_voice1 = $urandom;
      r.step_voice2 = $urandom;
      r.note_length = 16'($urandom);
      r.voice_count = 2'($urandom);
      return r;
   endfunction

   // Present one request and hold it until taken. Valid stays high afterwards,
   // so the next call (or settle) must assign it at the following falling edge.
   task automatic put_request(input psns_req_type item);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.cmd != CMD_SPARE) items_sent++;
   endtask

   task automatic send_tick();
      put_request(scrambled_request(CMD_TICK));
      ticks_sent++;
   endtask

   task automatic restart_song();
      put_request(scrambled_request(CMD_RESTART));
      restarts_sent++;
   endtask

   task automatic load_note(input logic [7:0] slot, input logic [15:0] len,
                            input logic [1:0] voices, input logic [95:0] steps);
      psns_req_type r;
      r             = scrambled_request(CMD_LOAD);
      r.note_addr   = slot;
      r.note_length = len;
      r.voice_count = voices;
      r.step_voice0 = steps[95:64];
      r.step_voice1 = steps[63:32];
      r.step_voice2 = steps[31:0];
      put_request(r);
      loads_sent++;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Drop valid, let every due sample come back, then give a load or a tick
   // still in the pipe time to finish before the registers move.
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // One song setting: move the registers, fill the window with short notes,
   // then play it with rewrites, stray loads, restarts and ignored commands.
   task automatic run_phase(input int unsigned p);
      logic [7:0]  new_first, slot;
      int unsigned new_notes, eff, ops, top_len, pattern, roll;
      settle();
      idle_on   = (items_sent - random_base < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      new_first = 8'($urandom);
      if ($urandom_range(0, 9) == 0) new_first = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      new_notes = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      // 0 start only, 1 length only, 2 start then length, 3 length then start
      pattern   = $urandom_range(0, 3);
      if (p == 0) begin
         // top slot and slot zero: the window wraps round the score
         new_first = 8'hFF;
         new_notes = 2;
         pattern   = 2;
      end
      if (p == 1) begin
         new_notes = 256;
         pattern   = 3;
      end
      if (p == 2) begin
         // a zero length plays like a one-note song
         new_notes = 0;
         pattern   = 1;
      end
      if (pattern == 1) new_first = window_first;
      eff = (pattern == 0) ? window_notes : ((new_notes == 0) ? 1 : new_notes);
      if (pattern == 3) write_reg(CSR_SONG_LENGTH, 9'(new_notes));
      if (pattern != 1) write_reg(CSR_SONG_START, {1'($urandom), new_first});
      if (pattern == 1 || pattern == 2) write_reg(CSR_SONG_LENGTH, 9'(new_notes));
      // a shrinking song may leave the position past its end: pull it back
      if (eff < window_notes || $urandom_range(0, 2) == 0) restart_song();
      window_first = new_first;
      window_notes = eff;
      settings_used++;
      top_len = (eff == 256) ? 2 : (($urandom_range(0, 3) == 0) ? 40 : 12);
      for (int i = 0; i < eff; i++)
         load_note(8'(window_first + i), 16'($urandom_range(0, top_len)), 2'($urandom),
                   {$urandom, $urandom, $urandom});
      ops = (eff == 256) ? 48 : $urandom_range(15, 60);
      repeat (ops) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            send_tick();
         end else if (roll < 88 || (roll < 93 && window_notes == 256)) begin
            // rewrite a note of the song, possibly the one playing
            slot = 8'(window_first + $urandom_range(0, window_notes - 1));
            load_note(slot, 16'($urandom_range(0, 12)), 2'($urandom),
                      {$urandom, $urandom, $urandom});
         end else if (roll < 93) begin
            // any length outside the window; a later fill that covers the slot overwrites it
            slot = 8'(window_first + window_notes + $urandom_range(0, 255 - window_notes));
            load_note(slot, 16'($urandom), 2'($urandom), {$urandom, $urandom, $urandom});
         end else if (roll < 97) begin
            restart_song();
         end else begin
            put_request(scrambled_request(CMD_SPARE));
            spares_sent++;
         end
      end
   endtask

   initial begin : stimulus
      psns_req_type junk;
      int unsigned  waited;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: default song of one note at slot zero.
      write_reg(CSR_SPARE_LO, 9'h1FF);
      write_reg(CSR_SPARE_HI, 9'h0AA);
      load_note(8'h00, 16'd3, 2'd3, {32'hFFFF_FFFF, 32'h0400_0000, 32'h0000_0000});
      repeat (3) send_tick();
      // rest with zero length: one silent sample, then the loop
      load_note(8'h00, 16'd0, 2'd0, {$urandom, $urandom, $urandom});
      send_tick();
      load_note(8'h00, 16'd1, 2'd1, {32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_tick();
      load_note(8'h00, 16'd2, 2'd2, {$urandom, $urandom, $urandom});
      send_tick();
      restart_song();
      repeat (3) send_tick();
      junk     = '1;
      junk.cmd = CMD_SPARE;
      put_request(junk);
      spares_sent++;
      // top slot with every field at its maximum; never played from here
      load_note(8'hFF, 16'hFFFF, 2'd3, {96{1'b1}});

      // Envelope walk on one long note.
      settle();
      write_reg(CSR_SONG_START, {1'b0, LONG_SLOT});
      write_reg(CSR_SONG_LENGTH, 9'd1);
      restart_song();
      window_first = LONG_SLOT;
      window_notes = 1;
      settings_used++;
      load_note(LONG_SLOT, LONG_NOTE, 2'd3, {$urandom, $urandom, $urandom});
      repeat (LONG_TICKS) send_tick();
      // cut the note below the position reached: silence, then the note ends
      load_note(LONG_SLOT, CUT_NOTE, 2'($urandom), {$urandom, $urandom, $urandom});
      send_tick();

      // Random song settings until enough requests have gone through.
      random_base = items_sent;
      for (int p = 0; items_sent - random_base < RANDOM_TARGET; p++) run_phase(p);

      // Drain.
      idle_on = 1'b0;
      @(negedge clock) req_valid <= 1'b0;
      for (waited = 0; awaiting != 0 && waited < DRAIN_LIMIT; waited++) @(negedge clock);
      if (awaiting != 0) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         repeat (10) @(negedge clock);
         $display("Covered %0d ticks, %0d note loads, %0d restarts, %0d ignored commands",
                  ticks_sent, loads_sent, restarts_sent, spares_sent);
         $display("over %0d song settings, with %0d song loops checked.",
                  settings_used, loops_seen);
         if (mismatches == 0) $display("DONE: 0 errors");
         else $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
